[hw/rtl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared widths, token and status codes, divider status and saturation helpers.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int VALUE_W  = 32;
   localparam int TYPE_W   = 2;
   localparam int OPCODE_W = 3;
   localparam int VAR_W    = 5;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 5;

   localparam logic [TYPE_W-1:0] TOK_PUSH = 2'd0;
   localparam logic [TYPE_W-1:0] TOK_OP   = 2'd1;
   localparam logic [TYPE_W-1:0] TOK_END  = 2'd2;

   localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_MOD = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIVZ  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LEFT  = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic signed [VALUE_W-1:0] sat33(input logic signed [VALUE_W:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v[VALUE_W] != v[VALUE_W-1]) begin
         r = v[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat64(input logic signed [63:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/rpn_if.sv]
// ----------------------------------------------------------------------------
// RPN evaluator channels
// Token request channel and result response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpn_req_if;
   logic                                valid;
   logic                                ready;
   logic [rpn_pkg::TYPE_W-1:0]          req_type;
   logic signed [rpn_pkg::VALUE_W-1:0]  operand_value;
   logic [rpn_pkg::OPCODE_W-1:0]        operator_code;
   logic [rpn_pkg::VAR_W-1:0]           dest_var;

   modport source (output valid, req_type, operand_value, operator_code, dest_var,
                   input ready);
   modport sink   (input valid, req_type, operand_value, operator_code, dest_var,
                   output ready);
endinterface

interface rpn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rpn_pkg::STATUS_W-1:0]        status;
   logic signed [rpn_pkg::VALUE_W-1:0]  result_value;
   logic                                result_valid;
   logic [rpn_pkg::VAR_W-1:0]           result_var;
   logic [rpn_pkg::DEPTH_W-1:0]         depth_now;

   modport source (output valid, status, result_value, result_valid, result_var,
                   depth_now, input ready);
   modport sink   (input valid, status, result_value, result_valid, result_var,
                   depth_now, output ready);
endinterface

[hw/rtl/rpn_divider.sv]
// ----------------------------------------------------------------------------
// RPN unsigned divider
// Restoring divider, one quotient bit per cycle, shared by divide and modulo.
// ----------------------------------------------------------------------------
module rpn_divider #(
   parameter int NUM_W = rpn_pkg::VALUE_W + rpn_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              dividend,
   input  logic [rpn_pkg::VALUE_W-1:0]   divisor,
   output rpn_pkg::div_status_type       div_st,
   output logic [NUM_W-1:0]              quotient,
   output logic [rpn_pkg::VALUE_W-1:0]   remainder
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0]   dsr_ff, dsr_in;
   logic [VALUE_W:0]     shifted;
   logic [VALUE_W:0]     diff;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (!diff[VALUE_W]) begin
            rem_in = diff[VALUE_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_st.busy = busy_ff;
   assign div_st.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

[hw/rtl/rpn_stack_evaluator_core.sv]
// ----------------------------------------------------------------------------
// RPN stack evaluator core
// Evaluates reverse-Polish tokens in signed fixed point on a memory stack.
//
// Tokens arrive on req_ch (push operand, operator, end of expression); each
// accepted request yields exactly one response on rsp_ch with status, value,
// final-value flag, destination variable and stack depth after the token.
// One token is processed at a time; req_ch.ready is high only while the
// sequencer is idle. The stack lives in a synchronous memory with two read
// ports and one write port; its top two entries are ready in the cycle after
// the token is taken. Push, add, subtract, end and ignored tokens go from
// execute to the result register; multiply adds a rounding state; divide and
// modulo wait on the shared divider, which yields one quotient bit per cycle.
// A result waits in the response register while the next token is taken; the
// sequencer holds its finished result only if the receiver still stalls.
// Reset empties the stack (depth 0) and clears the response valid; stack
// entries keep no reset value and are never used before being written.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rpn_req_if.sink    req_ch,
   rpn_rsp_if.source  rsp_ch
);
   import rpn_pkg::*;

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int NUM_W = VALUE_W + FRAC_BITS;
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [VALUE_W:0] HALF = (VALUE_W+1)'(((VALUE_W+1)'(1) << FRAC_BITS) >> 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [TYPE_W-1:0]          kind_ff, kind_in;
   logic [OPCODE_W-1:0]        code_ff, code_in;
   logic signed [VALUE_W-1:0]  opv_ff, opv_in;
   logic [VAR_W-1:0]           var_ff, var_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              cnt_next_ff, cnt_next_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic signed [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                       res_valid_ff, res_valid_in;
   logic                       wr_en_ff, wr_en_in;
   logic [AW-1:0]              wr_addr_ff, wr_addr_in;
   logic                       neg_ff, neg_in;
   logic                       mod_ff, mod_in;
   logic signed [63:0]         prod_ff, prod_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_rvalid_ff, rsp_rvalid_in;
   logic [VAR_W-1:0]           rsp_var_ff, rsp_var_in;
   logic [CW-1:0]              rsp_depth_ff, rsp_depth_in;

   logic [VALUE_W-1:0]         value_stack_mem [STACK_DEPTH];
   logic signed [VALUE_W-1:0]  rd_a_ff, rd_b_ff;

   logic [CW-1:0]              cnt_m1, cnt_m2;
   logic                       req_acc, fin_go;
   logic signed [VALUE_W-1:0]  top_val;
   logic signed [VALUE_W:0]    add_sum, sub_diff;
   logic signed [VALUE_W:0]    a_half, b_half, ia, ib, ia_abs, ib_abs;
   logic [VALUE_W-1:0]         ia_mag, ib_mag, a_abs, b_abs;
   logic signed [63:0]         mul_sum, mul_shift;
   logic signed [63:0]         div_mag, div_signed;

   logic                       div_start;
   logic [NUM_W-1:0]           div_dividend;
   logic [VALUE_W-1:0]         div_divisor;
   div_status_type             div_st;
   logic [NUM_W-1:0]           div_quo;
   logic [VALUE_W-1:0]         div_rem;

   rpn_divider #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .div_st    (div_st),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign fin_go       = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   assign cnt_m1  = count_ff - CW'(1);
   assign cnt_m2  = count_ff - CW'(2);
   assign top_val = (count_ff != '0) ? rd_b_ff : '0;

   assign add_sum  = {rd_a_ff[VALUE_W-1], rd_a_ff} + {rd_b_ff[VALUE_W-1], rd_b_ff};
   assign sub_diff = {rd_a_ff[VALUE_W-1], rd_a_ff} - {rd_b_ff[VALUE_W-1], rd_b_ff};

   // round half up to integer
   assign a_half = {rd_a_ff[VALUE_W-1], rd_a_ff} + HALF;
   assign b_half = {rd_b_ff[VALUE_W-1], rd_b_ff} + HALF;
   assign ia     = a_half >>> FRAC_BITS;
   assign ib     = b_half >>> FRAC_BITS;
   assign ia_abs = ia[VALUE_W] ? -ia : ia;
   assign ib_abs = ib[VALUE_W] ? -ib : ib;
   assign ia_mag = ia_abs[VALUE_W-1:0];
   assign ib_mag = ib_abs[VALUE_W-1:0];
   assign a_abs  = rd_a_ff[VALUE_W-1] ? (VALUE_W'(0) - rd_a_ff) : rd_a_ff;
   assign b_abs  = rd_b_ff[VALUE_W-1] ? (VALUE_W'(0) - rd_b_ff) : rd_b_ff;

   assign div_dividend = (code_ff == OP_MOD) ? NUM_W'(ia_mag) : (NUM_W'(a_abs) << FRAC_BITS);
   assign div_divisor  = (code_ff == OP_MOD) ? ib_mag : b_abs;

   assign mul_sum   = prod_ff + 64'(HALF);
   assign mul_shift = mul_sum >>> FRAC_BITS;

   assign div_mag    = mod_ff ? (64'(div_rem) << FRAC_BITS) : 64'(div_quo);
   assign div_signed = neg_ff ? -div_mag : div_mag;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      code_in       = code_ff;
      opv_in        = opv_ff;
      var_in        = var_ff;
      count_in      = count_ff;
      cnt_next_in   = cnt_next_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_valid_in  = res_valid_ff;
      wr_en_in      = wr_en_ff;
      wr_addr_in    = wr_addr_ff;
      neg_in        = neg_ff;
      mod_in        = mod_ff;
      prod_in       = prod_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_depth_in  = rsp_depth_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               kind_in  = req_ch.req_type;
               code_in  = req_ch.operator_code;
               opv_in   = req_ch.operand_value;
               var_in   = req_ch.dest_var;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = STATUS_OK;
            res_value_in  = '0;
            res_valid_in  = 1'b0;
            wr_en_in      = 1'b0;
            wr_addr_in    = cnt_m2[AW-1:0];
            cnt_next_in   = '0;
            state_in      = S_FIN;
            case (kind_ff)
               TOK_PUSH: begin
                  if (count_ff >= DEPTH_C) begin
                     res_status_in = STATUS_OVER;
                  end else begin
                     res_value_in = opv_ff;
                     wr_en_in     = 1'b1;
                     wr_addr_in   = count_ff[AW-1:0];
                     cnt_next_in  = count_ff + CW'(1);
                  end
               end
               TOK_OP: begin
                  if (code_ff > OP_MOD) begin
                     res_value_in = top_val;
                     cnt_next_in  = count_ff;
                  end else if (count_ff < CW'(2)) begin
                     res_status_in = STATUS_UNDER;
                  end else begin
                     wr_en_in    = 1'b1;
                     cnt_next_in = cnt_m1;
                     case (code_ff)
                        OP_ADD: res_value_in = sat33(add_sum);
                        OP_SUB: res_value_in = sat33(sub_diff);
                        OP_MUL: begin
                           prod_in  = 64'(rd_a_ff) * 64'(rd_b_ff);
                           state_in = S_MUL;
                        end
                        OP_DIV: begin
                           if (rd_b_ff == '0) begin
                              res_status_in = STATUS_DIVZ;
                              wr_en_in      = 1'b0;
                              cnt_next_in   = '0;
                           end else begin
                              neg_in    = rd_a_ff[VALUE_W-1] ^ rd_b_ff[VALUE_W-1];
                              mod_in    = 1'b0;
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                        end
                        default: begin
                           if (ib == '0) begin
                              res_status_in = STATUS_DIVZ;
                              wr_en_in      = 1'b0;
                              cnt_next_in   = '0;
                           end else begin
                              neg_in    = ia[VALUE_W];
                              mod_in    = 1'b1;
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                        end
                     endcase
                  end
               end
               TOK_END: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_UNDER;
                  end else if (cnt_m1 != '0) begin
                     res_status_in = STATUS_LEFT;
                  end else begin
                     res_value_in = rd_b_ff;
                     res_valid_in = 1'b1;
                  end
               end
               default: begin
                  res_value_in = top_val;
                  cnt_next_in  = count_ff;
               end
            endcase
         end
         S_MUL: begin
            res_value_in = sat64(mul_shift);
            state_in     = S_FIN;
         end
         S_DIV: begin
            if (div_st.done) begin
               res_value_in = sat64(div_signed);
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_rvalid_in = res_valid_ff;
               rsp_var_in    = var_ff;
               rsp_depth_in  = cnt_next_ff;
               count_in      = cnt_next_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      code_ff       <= code_in;
      opv_ff        <= opv_in;
      var_ff        <= var_in;
      cnt_next_ff   <= cnt_next_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_valid_ff  <= res_valid_in;
      wr_en_ff      <= wr_en_in;
      wr_addr_ff    <= wr_addr_in;
      neg_ff        <= neg_in;
      mod_ff        <= mod_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // read top two entries every cycle; writes land only when leaving S_FIN
   always_ff @(posedge clock) begin
      if (fin_go && wr_en_ff) begin
         value_stack_mem[wr_addr_ff] <= res_value_ff;
      end
      rd_b_ff <= value_stack_mem[cnt_m1[AW-1:0]];
      rd_a_ff <= value_stack_mem[cnt_m2[AW-1:0]];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.result_valid = rsp_rvalid_ff;
   assign rsp_ch.result_var   = rsp_var_ff;
   assign rsp_ch.depth_now    = DEPTH_W'(rsp_depth_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack count exceeds depth");

   a_final_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rvalid_ff |-> rsp_status_ff == STATUS_OK && rsp_depth_ff == '0)
      else $error("final value with nonempty stack or error status");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_value_ff == '0 && rsp_depth_ff == '0)
      else $error("error response without cleared stack");

   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_st.busy || div_st.done |-> state_ff == S_DIV)
      else $error("divider active outside divide state");

   a_fin_commit: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> rsp_valid_ff && count_ff == rsp_depth_ff && state_ff == S_IDLE)
      else $error("response and stack count disagree after commit");

endmodule
